>>> rtl/sdspi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, register map and constants of the SD SPI command transceiver.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    // Command frame geometry
    localparam int CMD_BYTES = 5;
    localparam int CMD_BITS  = CMD_BYTES * 8;
    localparam int SEND_BITS = CMD_BITS + 8;

    localparam logic [5:0] CMD_BITS_LAST = 6'(CMD_BITS - 1);
    localparam logic [5:0] SEND_BITS_W   = 6'(SEND_BITS);
    localparam logic [5:0] BYTE_BITS     = 6'd8;

    // Response length bounds
    localparam logic [2:0] MIN_RESP_BYTES = 3'd1;
    localparam logic [2:0] MAX_RESP_BYTES = 3'd5;

    // CRC7 polynomial x^7 + x^3 + 1, low terms
    localparam logic [6:0] CRC7_POLY = 7'h09;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_BUSY          = 2'd0;
    localparam logic [1:0] STATUS_OK            = 2'd1;
    localparam logic [1:0] STATUS_READY_TIMEOUT = 2'd2;
    localparam logic [1:0] STATUS_START_TIMEOUT = 2'd3;

    // Register map (word index = paddr[3:2])
    localparam int         PADDR_W            = 4;
    localparam logic [1:0] REG_READY_POLL     = 2'd0;
    localparam logic [1:0] REG_START_SEARCH   = 2'd1;
    localparam logic [1:0] REG_TAIL_BYTES     = 2'd2;

    // Register reset values
    localparam logic [15:0] READY_POLL_RESET   = 16'd10000;
    localparam logic [7:0]  START_SEARCH_RESET = 8'd20;
    localparam logic [3:0]  TAIL_BYTES_RESET   = 4'd10;

    typedef struct packed {
        logic        action;
        logic [39:0] command;
        logic [2:0]  response_bytes;
        logic        miso;
    } in_word_t;

    typedef struct packed {
        logic        mosi;
        logic        clock_pulse;
        logic        done_res;
        logic [1:0]  status;
        logic [39:0] response;
    } out_word_t;

    typedef struct packed {
        logic [15:0] ready_poll_limit;
        logic [7:0]  start_search_limit;
        logic [3:0]  tail_byte_limit;
    } cfg_t;

    // One bit of the SD CRC7, MSB first
    function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic din);
        logic fb;
        fb = crc[6] ^ din;
        return {crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
    endfunction

endpackage

>>> rtl/sdspi_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_regs
// APB configuration registers: ready poll limit, start search limit and
// tail byte limit.
// ----------------------------------------------------------------------------
module sdspi_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdspi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output sdspi_pkg::cfg_t               cfg
);

    sdspi_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write the addressed register in the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ready_poll_limit   <= sdspi_pkg::READY_POLL_RESET;
            cfg_reg.start_search_limit <= sdspi_pkg::START_SEARCH_RESET;
            cfg_reg.tail_byte_limit    <= sdspi_pkg::TAIL_BYTES_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                sdspi_pkg::REG_READY_POLL:   cfg_reg.ready_poll_limit   <= pwdata[15:0];
                sdspi_pkg::REG_START_SEARCH: cfg_reg.start_search_limit <= pwdata[7:0];
                sdspi_pkg::REG_TAIL_BYTES:   cfg_reg.tail_byte_limit    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended
    always_comb begin
        case (reg_idx)
            sdspi_pkg::REG_READY_POLL:   prdata = {16'h0000, cfg_reg.ready_poll_limit};
            sdspi_pkg::REG_START_SEARCH: prdata = {24'h000000, cfg_reg.start_search_limit};
            sdspi_pkg::REG_TAIL_BYTES:   prdata = {28'h0000000, cfg_reg.tail_byte_limit};
            default:                     prdata = 32'h0000_0000;
        endcase
    end

endmodule

>>> rtl/sd_spi_command_transceiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_command_transceiver_core
// SD card SPI-mode command engine, one input word per SCK cycle.
// ----------------------------------------------------------------------------
// Each input word is either a start (latches the five command bytes and the
// response length) or one SCK tick carrying the sampled MISO bit. Every word
// produces exactly one result word giving MOSI, whether SCK pulses, and on
// the last tick the status and received response. The engine takes one word
// per clock cycle and registers its result for the next cycle; all state
// advances as the word is taken. A new word is taken in the same cycle the
// previous result is taken, while a result that waits on m_ready holds the
// input off. The CRC7 is built bit-serially while the command bits go out,
// so it is ready exactly when the trailer byte is due.
// Limits are set through the APB registers (ready poll, start search, tail
// bytes) and should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module sd_spi_command_transceiver_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sdspi_pkg::in_word_t           s_data,
    // Result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output sdspi_pkg::out_word_t          m_data,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdspi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_READY  = 3'd1,
        PH_SEND   = 3'd2,
        PH_SEARCH = 3'd3,
        PH_RECV   = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    sdspi_pkg::cfg_t cfg;

    phase_t      phase_reg,       phase_next;
    logic [47:0] send_shift_reg,  send_shift_next;
    logic [39:0] recv_shift_reg,  recv_shift_next;
    logic [5:0]  bit_count_reg,   bit_count_next;
    logic [3:0]  byte_count_reg,  byte_count_next;
    logic [15:0] wait_count_reg,  wait_count_next;
    logic        seen_high_reg,   seen_high_next;
    logic [2:0]  expected_len_reg, expected_len_next;
    logic [6:0]  crc_reg,         crc_next;

    logic                 m_valid_reg;
    sdspi_pkg::out_word_t m_data_reg, res_next;

    logic        accept;
    logic [5:0]  bit_inc;
    logic [15:0] wait_inc;
    logic [3:0]  byte_inc;
    logic [39:0] recv_in;
    logic [7:0]  tail_in;
    logic [2:0]  len_clamped;

    sdspi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a word whenever the result register is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign bit_inc  = bit_count_reg + 6'd1;
    assign wait_inc = wait_count_reg + 16'd1;
    assign byte_inc = byte_count_reg + 4'd1;
    assign recv_in  = {recv_shift_reg[38:0], s_data.miso};
    assign tail_in  = {send_shift_reg[6:0], s_data.miso};

    // Clamp the response length to one..five bytes
    always_comb begin
        if (s_data.response_bytes == 3'd0) begin
            len_clamped = sdspi_pkg::MIN_RESP_BYTES;
        end else if (s_data.response_bytes > sdspi_pkg::MAX_RESP_BYTES) begin
            len_clamped = sdspi_pkg::MAX_RESP_BYTES;
        end else begin
            len_clamped = s_data.response_bytes;
        end
    end

    // Next state and result for the word at the input
    always_comb begin
        phase_next        = phase_reg;
        send_shift_next   = send_shift_reg;
        recv_shift_next   = recv_shift_reg;
        bit_count_next    = bit_count_reg;
        byte_count_next   = byte_count_reg;
        wait_count_next   = wait_count_reg;
        seen_high_next    = seen_high_reg;
        expected_len_next = expected_len_reg;
        crc_next          = crc_reg;

        res_next.mosi        = 1'b1;
        res_next.clock_pulse = 1'b0;
        res_next.done_res    = 1'b0;
        res_next.status      = sdspi_pkg::STATUS_BUSY;
        res_next.response    = 40'd0;

        if (s_data.action == sdspi_pkg::ACT_START) begin
            // Latch command; trailer byte is filled in once the CRC is known
            expected_len_next = len_clamped;
            send_shift_next   = {s_data.command, 8'h00};
            recv_shift_next   = 40'd0;
            bit_count_next    = 6'd0;
            byte_count_next   = 4'd0;
            wait_count_next   = 16'd0;
            seen_high_next    = 1'b0;
            crc_next          = 7'd0;
            phase_next        = PH_READY;
        end else begin
            case (phase_reg)
                PH_READY: begin
                    // Poll MISO without clocking
                    if (s_data.miso) begin
                        bit_count_next = 6'd0;
                        phase_next     = PH_SEND;
                    end else begin
                        wait_count_next = wait_inc;
                        if (wait_inc == 16'd0 || wait_inc >= cfg.ready_poll_limit) begin
                            res_next.done_res = 1'b1;
                            res_next.status   = sdspi_pkg::STATUS_READY_TIMEOUT;
                            phase_next        = PH_IDLE;
                        end
                    end
                end
                PH_SEND: begin
                    // Shift out MSB first, folding command bits into the CRC
                    res_next.mosi        = send_shift_reg[47];
                    res_next.clock_pulse = 1'b1;
                    bit_count_next       = bit_inc;
                    if (bit_count_reg <= sdspi_pkg::CMD_BITS_LAST) begin
                        crc_next = sdspi_pkg::crc7_step(crc_reg, send_shift_reg[47]);
                    end
                    if (bit_count_reg == sdspi_pkg::CMD_BITS_LAST) begin
                        send_shift_next = {crc_next, 1'b1, 40'd0};
                    end else begin
                        send_shift_next = {send_shift_reg[46:0], 1'b0};
                    end
                    if (bit_inc >= sdspi_pkg::SEND_BITS_W) begin
                        wait_count_next = 16'd0;
                        seen_high_next  = 1'b0;
                        phase_next      = PH_SEARCH;
                    end
                end
                PH_SEARCH: begin
                    // Look for a one followed by a zero
                    if (seen_high_reg && !s_data.miso) begin
                        recv_shift_next = 40'd0;
                        bit_count_next  = 6'd1;
                        byte_count_next = 4'd0;
                        phase_next      = PH_RECV;
                    end else begin
                        if (s_data.miso) begin
                            seen_high_next = 1'b1;
                        end
                        res_next.clock_pulse = 1'b1;
                        wait_count_next      = wait_inc;
                        if (wait_inc >= {8'd0, cfg.start_search_limit}) begin
                            res_next.done_res = 1'b1;
                            res_next.status   = sdspi_pkg::STATUS_START_TIMEOUT;
                            phase_next        = PH_IDLE;
                        end
                    end
                end
                PH_RECV: begin
                    // Shift in response bits
                    res_next.clock_pulse = 1'b1;
                    recv_shift_next      = recv_in;
                    bit_count_next       = bit_inc;
                    if (bit_inc >= sdspi_pkg::BYTE_BITS) begin
                        bit_count_next  = 6'd0;
                        byte_count_next = byte_inc;
                        if (byte_inc >= {1'b0, expected_len_reg}) begin
                            if (recv_in[7] && cfg.tail_byte_limit != 4'd0) begin
                                wait_count_next = 16'd0;
                                send_shift_next = 48'd0;
                                phase_next      = PH_TAIL;
                            end else begin
                                res_next.done_res = 1'b1;
                                res_next.status   = sdspi_pkg::STATUS_OK;
                                res_next.response = recv_in;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                end
                PH_TAIL: begin
                    // Clock in and drop tail bytes while their MSB stays one, up to the tail byte limit
                    res_next.clock_pulse = 1'b1;
                    send_shift_next      = {40'd0, tail_in};
                    bit_count_next       = bit_inc;
                    if (bit_inc >= sdspi_pkg::BYTE_BITS) begin
                        bit_count_next  = 6'd0;
                        wait_count_next = wait_inc;
                        if (!tail_in[7] || wait_inc >= {12'd0, cfg.tail_byte_limit}) begin
                            res_next.done_res = 1'b1;
                            res_next.status   = sdspi_pkg::STATUS_OK;
                            res_next.response = recv_shift_reg;
                            phase_next        = PH_IDLE;
                        end else begin
                            send_shift_next = 48'd0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            send_shift_reg   <= 48'd0;
            recv_shift_reg   <= 40'd0;
            bit_count_reg    <= 6'd0;
            byte_count_reg   <= 4'd0;
            wait_count_reg   <= 16'd0;
            seen_high_reg    <= 1'b0;
            expected_len_reg <= sdspi_pkg::MIN_RESP_BYTES;
            crc_reg          <= 7'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg        <= phase_next;
                send_shift_reg   <= send_shift_next;
                recv_shift_reg   <= recv_shift_next;
                bit_count_reg    <= bit_count_next;
                byte_count_reg   <= byte_count_next;
                wait_count_reg   <= wait_count_next;
                seen_high_reg    <= seen_high_next;
                expected_len_reg <= expected_len_next;
                crc_reg          <= crc_next;
                m_valid_reg      <= 1'b1;
                m_data_reg       <= res_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/sdspi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks of the SD SPI command transceiver, bound to the top level.
// ----------------------------------------------------------------------------
module sdspi_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input sdspi_pkg::in_word_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input sdspi_pkg::out_word_t m_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Every accepted word yields a result in the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");

    // A start word answers with an idle line and no completion
    a_start_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == sdspi_pkg::ACT_START |=>
            m_data.mosi && !m_data.clock_pulse && !m_data.done_res &&
            m_data.status == sdspi_pkg::STATUS_BUSY)
        else $error("start word result not quiet");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sd_spi_command_transceiver_core sdspi_checker u_sdspi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
